// File: design/dwc_pkg.sv
// Shared constants and word types for the deque with cursor.
`timescale 1ns / 1ps

package dwc_pkg;

  localparam int unsigned DEPTH = 16;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  localparam int KIND_W = 4;
  localparam int DATA_W = 64;
  localparam int STAT_W = 2;
  localparam int OCC_W = 5;
  localparam int POS_W = 4;

  localparam logic [KIND_W-1:0] K_START = 4'd0;
  localparam logic [KIND_W-1:0] K_CLEAR = 4'd1;
  localparam logic [KIND_W-1:0] K_PUSH_R = 4'd2;
  localparam logic [KIND_W-1:0] K_PUSH_L = 4'd3;
  localparam logic [KIND_W-1:0] K_POP_R = 4'd4;
  localparam logic [KIND_W-1:0] K_POP_L = 4'd5;
  localparam logic [KIND_W-1:0] K_CUR_L = 4'd6;
  localparam logic [KIND_W-1:0] K_CUR_R = 4'd7;
  localparam logic [KIND_W-1:0] K_SWAP_L = 4'd8;
  localparam logic [KIND_W-1:0] K_SWAP_R = 4'd9;

  localparam logic [STAT_W-1:0] ST_OK = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL = 2'd2;
  localparam logic [STAT_W-1:0] ST_NOEFFECT = 2'd3;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [DATA_W-1:0] value;
  } dwc_req_t;

  typedef struct packed {
    logic [DATA_W-1:0] popped_value;
    logic [STAT_W-1:0] status;
    logic [OCC_W-1:0]  occupancy;
    logic              cursor_valid;
    logic [POS_W-1:0]  cursor_position;
  } dwc_rsp_t;

  typedef struct packed {
    logic accept;
    logic pop_capture;
    logic swap_save;
    logic swap_wr_a;
    logic swap_wr_b;
  } dwc_cmd_t;

  typedef struct packed {
    logic need_pop;
    logic need_swap;
  } dwc_stat_t;

endpackage

// File: design/dwc_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module dwc_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16,
  parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: design/dwc_datapath.sv
// Datapath: ring storage, left-end pointer and fill count, cursor and result register.
`timescale 1ns / 1ps

module dwc_datapath (
  input  logic              clk,
  input  logic              rst,
  input  dwc_pkg::dwc_req_t req,
  input  dwc_pkg::dwc_cmd_t cmd,
  output dwc_pkg::dwc_stat_t stat,
  output dwc_pkg::dwc_rsp_t rsp
);
  import dwc_pkg::*;

  localparam int SUM_W = IDX_W + 1;
  localparam logic [SUM_W-1:0] DEPTH_SUM = SUM_W'(DEPTH);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] base,
                                               input logic [IDX_W-1:0] pos);
    logic [SUM_W-1:0] sum;
    sum = {1'b0, base} + {1'b0, pos};
    if (sum >= DEPTH_SUM) begin
      sum = sum - DEPTH_SUM;
    end
    return sum[IDX_W-1:0];
  endfunction

  logic [IDX_W-1:0] left, left_next;
  logic [CNT_W-1:0] fill, fill_next;
  logic [IDX_W-1:0] coff, coff_next;
  logic             cpres, cpres_next;
  logic [IDX_W-1:0] swap_a, swap_b, swap_a_next, swap_b_next;
  logic [DATA_W-1:0] swap_tmp;
  dwc_rsp_t         rsp_q;
  logic [STAT_W-1:0] status_next;

  logic              acc_we;
  logic [IDX_W-1:0]  acc_waddr;
  logic [IDX_W-1:0]  acc_raddr;
  logic              we;
  logic [IDX_W-1:0]  waddr, raddr;
  logic [DATA_W-1:0] wdata, rdata;
  logic [CNT_W-1:0]  fill_dec;

  assign fill_dec = fill - 1'b1;

  always_comb begin
    left_next = left;
    fill_next = fill;
    coff_next = coff;
    cpres_next = cpres;
    swap_a_next = swap_a;
    swap_b_next = swap_b;
    status_next = ST_OK;
    acc_we = 1'b0;
    acc_waddr = left;
    acc_raddr = left;
    stat = '0;
    unique case (req.kind)
      K_START: begin
        left_next = '0;
        fill_next = CNT_W'(1);
        coff_next = '0;
        cpres_next = 1'b1;
        acc_we = 1'b1;
        acc_waddr = '0;
      end
      K_CLEAR: begin
        left_next = '0;
        fill_next = '0;
        coff_next = '0;
        cpres_next = 1'b0;
      end
      K_PUSH_R: begin
        if (fill == FULL_CNT) begin
          status_next = ST_FULL;
        end else begin
          acc_we = 1'b1;
          acc_waddr = slot_of(left, IDX_W'(fill));
          fill_next = fill + 1'b1;
        end
      end
      K_PUSH_L: begin
        if (fill == FULL_CNT) begin
          status_next = ST_FULL;
        end else begin
          left_next = (left == '0) ? LAST_IDX : left - 1'b1;
          acc_we = 1'b1;
          acc_waddr = left_next;
          fill_next = fill + 1'b1;
          if (cpres) begin
            coff_next = coff + 1'b1;
          end
        end
      end
      K_POP_R: begin
        if (fill == '0) begin
          status_next = ST_EMPTY;
        end else begin
          stat.need_pop = 1'b1;
          fill_next = fill_dec;
          acc_raddr = slot_of(left, IDX_W'(fill_dec));
          if (cpres && CNT_W'(coff) >= fill_dec) begin
            if (fill_dec != '0) begin
              coff_next = IDX_W'(fill_dec - 1'b1);
            end else begin
              cpres_next = 1'b0;
              coff_next = '0;
            end
          end
        end
      end
      K_POP_L: begin
        if (fill == '0) begin
          status_next = ST_EMPTY;
        end else begin
          stat.need_pop = 1'b1;
          acc_raddr = left;
          left_next = (left == LAST_IDX) ? '0 : left + 1'b1;
          fill_next = fill_dec;
          if (cpres) begin
            if (coff == '0) begin
              if (fill_dec == '0) begin
                cpres_next = 1'b0;
              end
            end else begin
              coff_next = coff - 1'b1;
            end
          end
        end
      end
      K_CUR_L: begin
        if (cpres && coff != '0) begin
          coff_next = coff - 1'b1;
        end else begin
          status_next = ST_NOEFFECT;
        end
      end
      K_CUR_R: begin
        if (cpres && (CNT_W'(coff) + 1'b1) < fill) begin
          coff_next = coff + 1'b1;
        end else begin
          status_next = ST_NOEFFECT;
        end
      end
      K_SWAP_L: begin
        if (cpres && coff != '0) begin
          stat.need_swap = 1'b1;
          swap_a_next = slot_of(left, coff);
          swap_b_next = slot_of(left, coff - 1'b1);
          acc_raddr = swap_a_next;
        end else begin
          status_next = ST_NOEFFECT;
        end
      end
      K_SWAP_R: begin
        if (cpres && (CNT_W'(coff) + 1'b1) < fill) begin
          stat.need_swap = 1'b1;
          swap_a_next = slot_of(left, coff);
          swap_b_next = slot_of(left, coff + 1'b1);
          acc_raddr = swap_a_next;
        end else begin
          status_next = ST_NOEFFECT;
        end
      end
      default: begin
        status_next = ST_NOEFFECT;
      end
    endcase
  end

  always_comb begin
    we = 1'b0;
    waddr = acc_waddr;
    wdata = req.value;
    raddr = acc_raddr;
    priority if (cmd.accept) begin
      we = acc_we;
    end else if (cmd.swap_save) begin
      raddr = swap_b;
    end else if (cmd.swap_wr_a) begin
      we = 1'b1;
      waddr = swap_a;
      wdata = rdata;
    end else if (cmd.swap_wr_b) begin
      we = 1'b1;
      waddr = swap_b;
      wdata = swap_tmp;
    end else begin
      we = 1'b0;
    end
  end

  dwc_ram #(
    .WIDTH(DATA_W),
    .DEPTH(DEPTH)
  ) u_ring (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      left <= '0;
      fill <= '0;
      coff <= '0;
      cpres <= 1'b0;
    end else if (cmd.accept) begin
      left <= left_next;
      fill <= fill_next;
      coff <= coff_next;
      cpres <= cpres_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      swap_a <= swap_a_next;
      swap_b <= swap_b_next;
      rsp_q.popped_value <= '0;
      rsp_q.status <= status_next;
      rsp_q.occupancy <= OCC_W'(fill_next);
      rsp_q.cursor_valid <= cpres_next;
      rsp_q.cursor_position <= cpres_next ? POS_W'(coff_next) : '0;
    end
    if (cmd.pop_capture) begin
      rsp_q.popped_value <= rdata;
    end
    if (cmd.swap_save) begin
      swap_tmp <= rdata;
    end
  end

  assign rsp = rsp_q;

endmodule

// File: design/dwc_ctrl.sv
// Controller: sequences pops and swaps and runs both handshakes.
`timescale 1ns / 1ps

module dwc_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_stall,
  output logic               rsp_valid,
  input  logic               rsp_stall,
  input  dwc_pkg::dwc_stat_t stat,
  output dwc_pkg::dwc_cmd_t  cmd
);
  import dwc_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_POP_RD,
    S_SWAP_RD,
    S_SWAP_WA,
    S_SWAP_WB
  } state_t;

  state_t state;
  logic   accept;
  logic   rsp_set;

  assign req_stall = !(state == S_IDLE && (!rsp_valid || !rsp_stall));
  assign accept = req_valid && !req_stall;
  assign rsp_set = (state == S_IDLE && accept && !stat.need_pop && !stat.need_swap) ||
                   state == S_POP_RD || state == S_SWAP_WB;

  always_comb begin
    cmd = '0;
    cmd.accept = accept;
    cmd.pop_capture = (state == S_POP_RD);
    cmd.swap_save = (state == S_SWAP_RD);
    cmd.swap_wr_a = (state == S_SWAP_WA);
    cmd.swap_wr_b = (state == S_SWAP_WB);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_set) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            priority if (stat.need_pop) begin
              state <= S_POP_RD;
            end else if (stat.need_swap) begin
              state <= S_SWAP_RD;
            end
          end
        end
        S_POP_RD: begin
          state <= S_IDLE;
        end
        S_SWAP_RD: begin
          state <= S_SWAP_WA;
        end
        S_SWAP_WA: begin
          state <= S_SWAP_WB;
        end
        S_SWAP_WB: begin
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// File: design/deque_with_cursor_core.sv
// Top level of the deque with cursor: controller and datapath.
// The result word is valid in the cycle after acceptance for most operations; a pop
// that removes a word first passes S_POP_RD, and a swap S_SWAP_RD, S_SWAP_WA, S_SWAP_WB.
// Most operations take one word per cycle; a pop or swap holds off new words until it is
// back in S_IDLE, and a stalled result word holds off the input.
// Reset empties the deque and drops the cursor; ring contents stay undefined until written.
`timescale 1ns / 1ps

module deque_with_cursor_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_stall,
  input  dwc_pkg::dwc_req_t req,
  output logic              rsp_valid,
  input  logic              rsp_stall,
  output dwc_pkg::dwc_rsp_t rsp
);
  import dwc_pkg::*;

  dwc_cmd_t  cmd;
  dwc_stat_t stat;

  dwc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  dwc_datapath u_datapath (
    .clk (clk),
    .rst (rst),
    .req (req),
    .cmd (cmd),
    .stat(stat),
    .rsp (rsp)
  );

endmodule

// File: test/deque_with_cursor_core_tb.sv
// Self-checking testbench for the deque with cursor, driven by directed and random operations.
`timescale 1ns / 1ps

module deque_with_cursor_core_tb;
  import dwc_pkg::*;

  localparam int WATCHDOG_LIMIT = 1000;
  localparam logic [KIND_W-1:0] K_FIRST_UNUSED = 4'd10;
  localparam logic [KIND_W-1:0] K_LAST_UNUSED = 4'd15;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  dwc_req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  dwc_rsp_t rsp;

  dwc_rsp_t expected_q[$];
  int errors = 0;
  bit idle_on = 1'b1;
  int stall_left = 0;
  int quiet_cycles = 0;

  logic [DATA_W-1:0] ring_words [DEPTH];
  int unsigned left_slot = 0;
  int unsigned fill = 0;
  int unsigned cur_pos = 0;
  bit cur_on = 1'b0;

  deque_with_cursor_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  always #4 clk = ~clk;

  function automatic void empty_deque();
    left_slot = 0;
    fill = 0;
    cur_pos = 0;
    cur_on = 1'b0;
  endfunction

  function automatic int unsigned slot(int unsigned pos);
    return (left_slot + pos) % DEPTH;
  endfunction

  function automatic dwc_rsp_t predict_word(logic [KIND_W-1:0] kind, logic [DATA_W-1:0] value);
    dwc_rsp_t r;
    int unsigned a;
    int unsigned b;
    logic [DATA_W-1:0] t;
    r = '0;
    r.status = ST_OK;
    case (kind)
      K_START: begin
        empty_deque();
        ring_words[0] = value;
        fill = 1;
        cur_on = 1'b1;
      end
      K_CLEAR: begin
        empty_deque();
      end
      K_PUSH_R: begin
        if (fill >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          ring_words[slot(fill)] = value;
          fill++;
        end
      end
      K_PUSH_L: begin
        if (fill >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          left_slot = (left_slot + DEPTH - 1) % DEPTH;
          ring_words[left_slot] = value;
          fill++;
          if (cur_on) cur_pos++;
        end
      end
      K_POP_R: begin
        if (fill == 0) begin
          r.status = ST_EMPTY;
        end else begin
          fill--;
          r.popped_value = ring_words[slot(fill)];
          if (cur_on && cur_pos >= fill) begin
            if (fill > 0) begin
              cur_pos = fill - 1;
            end else begin
              cur_on = 1'b0;
              cur_pos = 0;
            end
          end
        end
      end
      K_POP_L: begin
        if (fill == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.popped_value = ring_words[left_slot];
          left_slot = (left_slot + 1) % DEPTH;
          fill--;
          if (cur_on) begin
            if (cur_pos == 0) begin
              if (fill == 0) cur_on = 1'b0;
            end else begin
              cur_pos--;
            end
          end
        end
      end
      K_CUR_L: begin
        if (cur_on && cur_pos > 0) cur_pos--;
        else r.status = ST_NOEFFECT;
      end
      K_CUR_R: begin
        if (cur_on && cur_pos + 1 < fill) cur_pos++;
        else r.status = ST_NOEFFECT;
      end
      K_SWAP_L, K_SWAP_R: begin
        if (!cur_on || (kind == K_SWAP_L && cur_pos == 0) ||
            (kind == K_SWAP_R && cur_pos + 1 >= fill)) begin
          r.status = ST_NOEFFECT;
        end else begin
          a = slot(cur_pos);
          b = slot(kind == K_SWAP_L ? cur_pos - 1 : cur_pos + 1);
          t = ring_words[a];
          ring_words[a] = ring_words[b];
          ring_words[b] = t;
        end
      end
      default: begin
        r.status = ST_NOEFFECT;
      end
    endcase
    r.occupancy = OCC_W'(fill);
    r.cursor_valid = cur_on;
    r.cursor_position = cur_on ? POS_W'(cur_pos) : '0;
    return r;
  endfunction

  function automatic logic [DATA_W-1:0] rand_word();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic send_word(input logic [KIND_W-1:0] kind, input logic [DATA_W-1:0] value);
    dwc_req_t w;
    w.kind = kind;
    w.value = value;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= w;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    expected_q.push_back(predict_word(kind, value));
  endtask

  task automatic wait_for_results();
    req_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
  endtask

  task automatic report_mismatch(input string field, input logic [DATA_W-1:0] want,
                                 input logic [DATA_W-1:0] got);
    $display("%0t: %s expected %h, got %h", $time, field, want, got);
    errors++;
  endtask

  task automatic test_directed();
    send_word(K_POP_L, rand_word());
    send_word(K_CUR_L, rand_word());
    send_word(K_PUSH_R, 64'h0123_4567_89ab_cdef);
    send_word(K_SWAP_R, rand_word());
    send_word(K_START, '1);
    send_word(K_PUSH_L, 64'h8000_0000_0000_0000);
    send_word(K_PUSH_R, '0);
    send_word(K_CUR_L, rand_word());
    send_word(K_CUR_L, rand_word());
    send_word(K_SWAP_R, rand_word());
    send_word(K_CUR_R, rand_word());
    send_word(K_CUR_R, rand_word());
    send_word(K_CUR_R, rand_word());
    send_word(K_SWAP_R, rand_word());
    send_word(K_SWAP_L, rand_word());
    send_word(K_POP_R, rand_word());
    send_word(K_POP_L, rand_word());
    send_word(K_POP_L, rand_word());
    send_word(K_POP_R, rand_word());
    send_word(K_START, 64'h5555_5555_5555_5555);
    send_word(K_PUSH_R, 64'haaaa_aaaa_aaaa_aaaa);
    send_word(K_CLEAR, rand_word());
    send_word(K_FIRST_UNUSED, rand_word());
    send_word(K_LAST_UNUSED, rand_word());
  endtask

  task automatic test_fill_and_drain();
    int extra;
    send_word(K_START, rand_word());
    extra = 0;
    while (extra < 3) begin
      if ($urandom_range(0, 3) == 0)
        send_word(K_CUR_L + KIND_W'($urandom_range(0, 3)), rand_word());
      send_word($urandom_range(0, 1) ? K_PUSH_R : K_PUSH_L, rand_word());
      if (fill == DEPTH) extra++;
    end
    wait_for_results();
    while (fill > 0) begin
      if ($urandom_range(0, 3) == 0)
        send_word(K_CUR_L + KIND_W'($urandom_range(0, 3)), rand_word());
      send_word($urandom_range(0, 1) ? K_POP_R : K_POP_L, rand_word());
    end
    send_word($urandom_range(0, 1) ? K_POP_R : K_POP_L, rand_word());
  endtask

  task automatic test_random_ops(input int count);
    int pick;
    logic [KIND_W-1:0] kind;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      if (pick < 3) kind = K_START;
      else if (pick < 5) kind = K_CLEAR;
      else if (pick < 25) kind = K_PUSH_R;
      else if (pick < 45) kind = K_PUSH_L;
      else if (pick < 57) kind = K_POP_R;
      else if (pick < 69) kind = K_POP_L;
      else if (pick < 77) kind = K_CUR_L;
      else if (pick < 85) kind = K_CUR_R;
      else if (pick < 91) kind = K_SWAP_L;
      else if (pick < 97) kind = K_SWAP_R;
      else kind = KIND_W'($urandom_range(K_FIRST_UNUSED, K_LAST_UNUSED));
      send_word(kind, rand_word());
    end
  endtask

  always @(posedge clk) begin
    if (stall_left > 0) begin
      rsp_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (idle_on && !rst && $urandom_range(0, 7) == 0) begin
      rsp_stall <= 1'b1;
      stall_left <= $urandom_range(0, 14);
    end else begin
      rsp_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    dwc_rsp_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result word %h", $time, rsp);
        errors++;
      end else begin
        want = expected_q.pop_front();
        if (rsp.popped_value !== want.popped_value)
          report_mismatch("popped_value", want.popped_value, rsp.popped_value);
        if (rsp.status !== want.status)
          report_mismatch("status", DATA_W'(want.status), DATA_W'(rsp.status));
        if (rsp.occupancy !== want.occupancy)
          report_mismatch("occupancy", DATA_W'(want.occupancy), DATA_W'(rsp.occupancy));
        if (rsp.cursor_valid !== want.cursor_valid)
          report_mismatch("cursor_valid", DATA_W'(want.cursor_valid),
                          DATA_W'(rsp.cursor_valid));
        if (rsp.cursor_position !== want.cursor_position)
          report_mismatch("cursor_position", DATA_W'(want.cursor_position),
                          DATA_W'(rsp.cursor_position));
      end
    end
  end

  always @(posedge clk) begin
    if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
      quiet_cycles <= 0;
    end else if (!rst) begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_fill_and_drain();
    test_random_ops(250);
    test_fill_and_drain();
    test_random_ops(180);
    idle_on = 1'b0;
    test_random_ops(100);
    wait_for_results();
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
